@@ hw/rtl/otfm_pkg.sv @@
// Shared types and constants for the overtemperature fault monitor.
`default_nettype none

package otfm_pkg;

    // Default number of samples in the averaging window.
    localparam int WINDOW_LEN_DEF = 3;

    // Request opcodes.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_PRIME  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SET_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SET_DELAY_MS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_DELAY_MS  = 2'd3;

    // Configuration reset values.
    localparam logic [7:0]  SET_THRESHOLD_RST   = 8'd100;
    localparam logic [7:0]  CLEAR_THRESHOLD_RST = 8'd90;
    localparam logic [15:0] SET_DELAY_MS_RST    = 16'd10;
    localparam logic [15:0] CLEAR_DELAY_MS_RST  = 16'd100;

    // One input request.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  sample;
        logic [31:0] now_ms;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic [7:0] average;
        logic       fault;
        logic       pending;
    } out_item_t;

endpackage : otfm_pkg

`default_nettype wire

@@ hw/rtl/overtemp_fault_monitor.sv @@
// Overtemperature fault monitor: moving average window and fault state flags.
//
//  Channel  Direction  Handshake              Payload
//  s_       in         s_valid / s_ready      s_data   (op, sample, now_ms)
//  m_       out        m_valid / m_ready      m_data   (average, fault, pending)
//  cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each request passes through the input register and then the output register, and one
// request is taken every cycle unless both registers hold undelivered requests.
// The window sum, slots and fault flags update in that single pass.
// Reset is synchronous on aresetn low and needs no clearing pass.
// An untaken result still lets the input register drain into a free output slot, so
// s_ready drops only while both registers hold undelivered requests; cfg_ready stays high.
`default_nettype none

module overtemp_fault_monitor #(
    parameter int WINDOW_LEN = otfm_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire otfm_pkg::in_item_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output otfm_pkg::out_item_t                      m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [otfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [otfm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import otfm_pkg::*;

    localparam int SLOT_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W     = $clog2(255 * WINDOW_LEN + 1);
    // Division by the window length as a multiply by a rounded-up reciprocal.
    localparam int DIV_SHIFT = SUM_W + 5;
    localparam int RECIP     = ((1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int PROD_W    = SUM_W + DIV_SHIFT + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

    // Configuration registers.
    logic [7:0]  set_threshold_reg;
    logic [7:0]  clear_threshold_reg;
    logic [15:0] set_delay_ms_reg;
    logic [15:0] clear_delay_ms_reg;

    // Pipeline registers.
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      adv;

    // Monitor state.
    logic [7:0]        window_reg [WINDOW_LEN];
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] prime_slot_reg, prime_slot_next;
    logic              fault_reg, fault_next;
    logic              pending_reg, pending_next;
    logic              timing_reg, timing_next;
    logic [31:0]       stamp_reg, stamp_next;

    // Datapath intermediates.
    logic [SLOT_W-1:0] slot_sel;
    logic [7:0]        old_entry;
    logic              is_replace;
    logic [PROD_W-1:0] avg_prod;
    logic [7:0]        avg;
    logic [31:0]       elapsed;
    logic [31:0]       recov_elapsed;
    out_item_t         out_next;
    logic [SUM_W-1:0]  sum_check;

    // Handshakes: the input register drains whenever the output slot is free or emptying.
    assign adv       = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || adv;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_threshold_reg   <= SET_THRESHOLD_RST;
            clear_threshold_reg <= CLEAR_THRESHOLD_RST;
            set_delay_ms_reg    <= SET_DELAY_MS_RST;
            clear_delay_ms_reg  <= CLEAR_DELAY_MS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SET_THRESHOLD:   set_threshold_reg   <= cfg_data[7:0];
                REG_CLEAR_THRESHOLD: clear_threshold_reg <= cfg_data[7:0];
                REG_SET_DELAY_MS:    set_delay_ms_reg    <= cfg_data;
                REG_CLEAR_DELAY_MS:  clear_delay_ms_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Window entry replacement and the new running sum.
    always_comb begin
        slot_sel   = (in_data_reg.op == OP_PRIME) ? prime_slot_reg : write_slot_reg;
        old_entry  = window_reg[slot_sel];
        is_replace = (in_data_reg.op == OP_SAMPLE) || (in_data_reg.op == OP_PRIME);
        sum_next   = is_replace
                   ? sum_reg - SUM_W'(old_entry) + SUM_W'(in_data_reg.sample)
                   : sum_reg;
        avg_prod   = PROD_W'(sum_next) * PROD_W'(RECIP);
        avg        = avg_prod[DIV_SHIFT +: 8];
        elapsed    = in_data_reg.now_ms - stamp_reg;
    end

    // Slot advance and the normal / pending / fault flag machine.
    always_comb begin
        write_slot_next = write_slot_reg;
        prime_slot_next = prime_slot_reg;
        fault_next      = fault_reg;
        pending_next    = pending_reg;
        timing_next     = timing_reg;
        stamp_next      = stamp_reg;
        recov_elapsed   = timing_reg ? elapsed : 32'd0;

        case (in_data_reg.op)
            OP_SAMPLE: begin
                write_slot_next = (write_slot_reg == LAST_SLOT) ? '0
                                : write_slot_reg + SLOT_W'(1);
                if (!fault_reg && !pending_reg) begin
                    if (avg >= set_threshold_reg) begin
                        pending_next = 1'b1;
                        stamp_next   = in_data_reg.now_ms;
                        timing_next  = 1'b1;
                    end
                end else if (pending_reg) begin
                    if (avg <= clear_threshold_reg) begin
                        pending_next = 1'b0;
                        timing_next  = 1'b0;
                    end else if (elapsed >= 32'(set_delay_ms_reg)) begin
                        pending_next = 1'b0;
                        fault_next   = 1'b1;
                        timing_next  = 1'b0;
                    end
                end else begin
                    // In fault: the first recovered sample starts the recovery timer.
                    if (avg <= clear_threshold_reg) begin
                        if (!timing_reg) begin
                            stamp_next  = in_data_reg.now_ms;
                            timing_next = 1'b1;
                        end
                        if (recov_elapsed >= 32'(clear_delay_ms_reg)) begin
                            fault_next  = 1'b0;
                            timing_next = 1'b0;
                        end
                    end else begin
                        timing_next = 1'b0;
                    end
                end
            end
            OP_PRIME: begin
                prime_slot_next = (prime_slot_reg == LAST_SLOT) ? '0
                                : prime_slot_reg + SLOT_W'(1);
                // The last priming sample sets the fault flag from the average.
                if (prime_slot_next == '0) begin
                    fault_next = (avg >= set_threshold_reg);
                end
            end
            OP_CLEAR: begin
                fault_next = 1'b0;
            end
            default: ;
        endcase

        out_next.average = avg;
        out_next.fault   = fault_next;
        out_next.pending = pending_next;
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            sum_reg        <= '0;
            write_slot_reg <= '0;
            prime_slot_reg <= '0;
            fault_reg      <= 1'b0;
            pending_reg    <= 1'b0;
            timing_reg     <= 1'b0;
            stamp_reg      <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                window_reg[i] <= '0;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (adv) begin
                sum_reg        <= sum_next;
                write_slot_reg <= write_slot_next;
                prime_slot_reg <= prime_slot_next;
                fault_reg      <= fault_next;
                pending_reg    <= pending_next;
                timing_reg     <= timing_next;
                stamp_reg      <= stamp_next;
                if (is_replace) begin
                    window_reg[slot_sel] <= in_data_reg.sample;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv) begin
            out_data_reg <= out_next;
        end
    end

    // Sum of the window entries, used to cross-check the running sum.
    always_comb begin
        sum_check = '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            sum_check = sum_check + SUM_W'(window_reg[i]);
        end
    end

    // The running sum always matches the window contents.
    a_sum_matches_window: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg == sum_check)
        else $error("running sum differs from window contents");

    // Both slot pointers stay inside the window.
    a_slots_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(write_slot_reg) < WINDOW_LEN) && (32'(prime_slot_reg) < WINDOW_LEN))
        else $error("slot pointer outside the window");

    // A clear request always reports the fault flag low.
    a_clear_drops_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && (in_data_reg.op == OP_CLEAR) |=> !m_data.fault)
        else $error("fault still reported after a clear request");

    // Input backpressure only while both stages hold an undelivered request.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

endmodule : overtemp_fault_monitor

`default_nettype wire

@@ sim/overtemp_fault_monitor_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the overtemperature fault monitor: requests checked against a predictor.

module overtemp_fault_monitor_tb;
    import otfm_pkg::*;

    localparam int         WIN          = WINDOW_LEN_DEF;
    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam int         DRAIN_CYCLES = 4;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor copy of the configuration and of the monitor state.
    logic [7:0]  thr_set = SET_THRESHOLD_RST;
    logic [7:0]  thr_clr = CLEAR_THRESHOLD_RST;
    logic [15:0] dly_set = SET_DELAY_MS_RST;
    logic [15:0] dly_clr = CLEAR_DELAY_MS_RST;
    logic [7:0]  win_mem [WIN] = '{default: 8'd0};
    int          win_total = 0;
    int          wr_pos = 0;
    int          pr_pos = 0;
    bit          flt = 1'b0;
    bit          pnd = 1'b0;
    bit          tmr = 1'b0;
    logic [31:0] mark_ms = 32'd0;

    out_item_t   expected_status [$];
    int          error_count = 0;
    bit          idle_en = 1'b1;
    logic [31:0] clock_ms = 32'd0;

    overtemp_fault_monitor #(.WINDOW_LEN(WIN)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Advance the predicted monitor state by one request and return the status it reports.
    function automatic out_item_t next_status(in_item_t req);
        out_item_t   res;
        logic [7:0]  avg;
        logic [31:0] elapsed;
        case (req.op)
            OP_SAMPLE: begin
                win_total = win_total - int'(win_mem[wr_pos]) + int'(req.sample);
                win_mem[wr_pos] = req.sample;
                wr_pos = (wr_pos + 1 >= WIN) ? 0 : wr_pos + 1;
                avg = 8'(win_total / WIN);
                if (!flt && !pnd) begin
                    if (avg >= thr_set) begin
                        pnd = 1'b1;
                        mark_ms = req.now_ms;
                        tmr = 1'b1;
                    end
                end else if (pnd) begin
                    // Pending wins over a fault flag that priming may have set.
                    elapsed = req.now_ms - mark_ms;
                    if (avg <= thr_clr) begin
                        pnd = 1'b0;
                        tmr = 1'b0;
                    end else if (elapsed >= {16'd0, dly_set}) begin
                        pnd = 1'b0;
                        flt = 1'b1;
                        tmr = 1'b0;
                    end
                end else begin
                    // Full fault: recovery must hold for the clear delay.
                    if (avg <= thr_clr) begin
                        if (!tmr) begin
                            mark_ms = req.now_ms;
                            tmr = 1'b1;
                        end
                        elapsed = req.now_ms - mark_ms;
                        if (elapsed >= {16'd0, dly_clr}) begin
                            flt = 1'b0;
                            tmr = 1'b0;
                        end
                    end else begin
                        tmr = 1'b0;
                    end
                end
            end
            OP_PRIME: begin
                win_total = win_total - int'(win_mem[pr_pos]) + int'(req.sample);
                win_mem[pr_pos] = req.sample;
                pr_pos = (pr_pos + 1 >= WIN) ? 0 : pr_pos + 1;
                avg = 8'(win_total / WIN);
                if (pr_pos == 0) flt = (avg >= thr_set);
            end
            OP_CLEAR: begin
                flt = 1'b0;
            end
            default: begin
            end
        endcase
        res.average = 8'(win_total / WIN);
        res.fault   = flt;
        res.pending = pnd;
        return res;
    endfunction

    // Send one request and record the status it should produce.
    task automatic send_request(input logic [1:0] op, input logic [7:0] temp,
                                input logic [31:0] now);
        in_item_t req;
        int       gap;
        req.op     = op;
        req.sample = temp;
        req.now_ms = now;
        gap = idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_status.push_back(next_status(req));
    endtask

    // Hold off new requests until every pending result has been delivered.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write one register and mirror it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_SET_THRESHOLD:   thr_set = val[7:0];
            REG_CLEAR_THRESHOLD: thr_clr = val[7:0];
            REG_SET_DELAY_MS:    dly_set = val;
            REG_CLEAR_DELAY_MS:  dly_clr = val;
            default: begin
            end
        endcase
    endtask

    // Reprogram all four registers once the monitor is idle.
    task automatic configure(input logic [15:0] set_thr, input logic [15:0] clr_thr,
                             input logic [15:0] set_dly, input logic [15:0] clr_dly);
        wait_idle();
        write_reg(REG_SET_THRESHOLD, set_thr);
        write_reg(REG_CLEAR_THRESHOLD, clr_thr);
        write_reg(REG_SET_DELAY_MS, set_dly);
        write_reg(REG_CLEAR_DELAY_MS, clr_dly);
        cfg_valid <= 1'b0;
    endtask

    // Priming at reset defaults: the last priming sample sets the fault flag, and
    // repeated priming replaces the window instead of adding to it.
    task automatic test_priming();
        send_request(OP_PRIME, 8'd255, 32'd0);
        send_request(OP_PRIME, 8'd255, 32'd0);
        send_request(OP_PRIME, 8'd255, 32'd0);
        send_request(OP_CLEAR, 8'd0, 32'd0);
        send_request(OP_PRIME, 8'd0, 32'd0);
        send_request(OP_PRIME, 8'd0, 32'd0);
        send_request(OP_PRIME, 8'd0, 32'd0);
        send_request(OP_NONE, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // Normal, pending and fault at reset defaults, with the time stamp wrapping,
    // a stamp dropped by a hot sample and a clear after exactly the clear delay.
    task automatic test_fault_cycle();
        send_request(OP_SAMPLE, 8'd255, 32'hFFFF_FFF0);
        send_request(OP_SAMPLE, 8'd255, 32'hFFFF_FFF2);
        send_request(OP_SAMPLE, 8'd255, 32'h0000_0004);
        send_request(OP_SAMPLE, 8'd95, 32'd10);
        send_request(OP_SAMPLE, 8'd0, 32'd20);
        send_request(OP_SAMPLE, 8'd0, 32'd30);
        send_request(OP_SAMPLE, 8'd200, 32'd50);
        send_request(OP_SAMPLE, 8'd255, 32'd60);
        send_request(OP_SAMPLE, 8'd0, 32'd70);
        send_request(OP_SAMPLE, 8'd0, 32'd80);
        send_request(OP_SAMPLE, 8'd0, 32'd179);
        send_request(OP_SAMPLE, 8'd0, 32'd180);
    endtask

    // Register extremes: pending taking precedence over a primed fault, a zero
    // clear delay clearing at once, then the largest thresholds and delays.
    task automatic test_extremes();
        configure(16'hFF00, 16'hA500, 16'd0, 16'd0);
        send_request(OP_SAMPLE, 8'd0, 32'd0);
        send_request(OP_PRIME, 8'd0, 32'd0);
        send_request(OP_PRIME, 8'd0, 32'd0);
        send_request(OP_PRIME, 8'd0, 32'd0);
        send_request(OP_SAMPLE, 8'd0, 32'd1);
        send_request(OP_SAMPLE, 8'd0, 32'd2);
        configure(16'h00FF, 16'h5AFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_SAMPLE, 8'd255, 32'hFFFF_FFFF);
        send_request(OP_SAMPLE, 8'd0, 32'd0);
    endtask

    // Random phase: fresh registers, then alternating hot and cold stretches of
    // samples with mostly advancing time, mixed with priming, clears and noise.
    task automatic test_random_traffic(input int count);
        int          seg_left;
        bit          hot;
        int          roll;
        logic [1:0]  op;
        logic [7:0]  temp;
        logic [31:0] now;
        logic [7:0]  set_thr;
        logic [7:0]  clr_thr;
        logic [15:0] set_dly;
        logic [15:0] clr_dly;
        set_thr = 8'($urandom_range(40, 220));
        clr_thr = set_thr - 8'($urandom_range(0, 30));
        case ($urandom_range(0, 9))
            0: begin
                set_thr = 8'd255;
                clr_thr = 8'd255;
            end
            1: begin
                set_thr = 8'd0;
                clr_thr = 8'd0;
            end
            2: clr_thr = 8'($urandom);
            default: begin
            end
        endcase
        case ($urandom_range(0, 9))
            0: set_dly = 16'd0;
            1: set_dly = 16'hFFFF;
            2: set_dly = 16'($urandom);
            default: set_dly = 16'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 9))
            0: clr_dly = 16'd0;
            1: clr_dly = 16'hFFFF;
            2: clr_dly = 16'($urandom);
            default: clr_dly = 16'($urandom_range(1, 40));
        endcase
        configure({8'($urandom), set_thr}, {8'($urandom), clr_thr}, set_dly, clr_dly);
        seg_left = 0;
        hot = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (seg_left == 0) begin
                hot = ~hot;
                seg_left = $urandom_range(4, 30);
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            if (roll < 10) temp = 8'($urandom);
            else if (hot) temp = 8'($urandom_range(255, set_thr));
            else temp = 8'($urandom_range(clr_thr));
            roll = $urandom_range(0, 99);
            if (roll < 82) op = OP_SAMPLE;
            else if (roll < 90) op = OP_PRIME;
            else if (roll < 95) op = OP_CLEAR;
            else op = OP_NONE;
            // Time mostly creeps forward, with the odd jump or out-of-order tick.
            roll = $urandom_range(0, 99);
            if (roll < 90) clock_ms = clock_ms + $urandom_range(0, 6);
            else if (roll < 96) clock_ms = clock_ms + $urandom_range(0, 200);
            else if (roll < 99) clock_ms = $urandom;
            now = (roll == 99) ? 32'($urandom) : clock_ms;
            send_request(op, temp, now);
            if (i == count / 2) wait_idle();
        end
    endtask

    // Result receiver with random stalls.
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = idle_en ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Compare each delivered result with the oldest predicted status.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_status.size() == 0) begin
                $error("result with no request outstanding: average %0d fault %0d pending %0d",
                       m_data.average, m_data.fault, m_data.pending);
                error_count++;
            end else begin
                want = expected_status.pop_front();
                if (m_data.average !== want.average) begin
                    $error("average: expected %0d, got %0d", want.average, m_data.average);
                    error_count++;
                end
                if (m_data.fault !== want.fault) begin
                    $error("fault: expected %0d, got %0d", want.fault, m_data.fault);
                    error_count++;
                end
                if (m_data.pending !== want.pending) begin
                    $error("pending: expected %0d, got %0d", want.pending, m_data.pending);
                    error_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

    // Test sequence.
    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_priming();
        test_fault_cycle();
        test_extremes();
        for (int p = 0; p < 6; p++) begin
            idle_en = (p % 3) != 2;
            test_random_traffic(142);
        end
        wait_idle();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/otfm_pkg.sv
hw/rtl/overtemp_fault_monitor.sv
sim/overtemp_fault_monitor_tb.sv
